// ===== design/i2a_pkg.sv =====
// Shared types, codes and character constants for the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package i2a_pkg;

	// Operand field width on the ports and default number of bits used
	localparam int VALUE_FIELD_W = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	// Operation codes
	typedef enum logic [1:0] {
		OP_CHAR = 2'd0,
		OP_DEC  = 2'd1,
		OP_HEX  = 2'd2,
		OP_PTR  = 2'd3
	} op_t;

	// Prefix lengths, in characters
	localparam logic [2:0] PFX_LEN_NONE = 3'd0;
	localparam logic [2:0] PFX_LEN_ONE  = 3'd1;
	localparam logic [2:0] PFX_LEN_HEX  = 3'd2;
	localparam logic [2:0] PFX_LEN_NIL  = 3'd5;

	// ASCII constants
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ALPHA = 8'h57; // 'a' - 10

	// Input request and output character payloads
	typedef struct packed {
		logic [1:0]               operation;
		logic [VALUE_FIELD_W-1:0] value;
	} arg_t;

	typedef struct packed {
		logic [7:0] ascii_byte;
		logic       last;
	} text_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       dab_step;
		logic       dig_shift;
		logic       emit_pfx;
		logic       emit_dig;
		logic [2:0] pidx;
		logic       last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       neg;
		logic       zero;
		logic       top_zero;
		logic       dcnt_one;
	} status_t;

	// One lowercase hex or decimal digit to ASCII
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] dw;
		dw = {4'h0, d};
		return (d < 4'd10) ? (CH_ZERO + dw) : (CH_ALPHA + dw);
	endfunction

	// Characters of "(nil)"
	function automatic logic [7:0] nil_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h28;
			3'd1:    c = 8'h6E;
			3'd2:    c = 8'h69;
			3'd3:    c = 8'h6C;
			default: c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

// ===== design/i2a_dpath.sv =====
// Datapath: operand capture, shift-add-3 BCD conversion, digit shifter and output register.
`timescale 1ns / 1ps

module i2a_dpath #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2a_pkg::arg_t     arg_data,
	input  i2a_pkg::cmd_t     cmd,
	output i2a_pkg::status_t  status,
	output i2a_pkg::text_t    text_data
);

	// Digits of the largest magnitude 2^(W-1) in decimal, and of W bits in hex
	localparam int DEC_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NDIG = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DIGW = NDIG * 4;
	localparam int CW = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0] vm;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [DIGW-1:0]        dig_q;
	logic [DIGW-1:0]        adj;
	logic [CW-1:0]          dcnt_q;
	logic [1:0]             op_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [3:0]             top;
	logic [7:0]             pfx_byte;
	i2a_pkg::text_t         out_q;

	assign vm  = arg_data.value[VALUE_WIDTH-1:0];
	assign top = dig_q[DIGW-1 -: 4];

	// Add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? (dig_q[i*4 +: 4] + 4'd3)
				: dig_q[i*4 +: 4];
		end
	end

	// Operand capture and per-item flags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= arg_data.operation;
			neg_q  <= (arg_data.operation == i2a_pkg::OP_DEC) && vm[VALUE_WIDTH-1];
			zero_q <= (vm == '0);
		end
	end

	// Binary shifter and digit register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (arg_data.operation == i2a_pkg::OP_DEC) begin
				bin_q <= vm[VALUE_WIDTH-1] ? (~vm + VALUE_WIDTH'(1)) : vm;
				dig_q <= '0;
			end else begin
				bin_q <= vm;
				dig_q <= DIGW'(vm);
			end
		end else if (cmd.dab_step) begin
			dig_q <= {adj[DIGW-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (cmd.dig_shift || cmd.emit_dig) begin
			dig_q <= {dig_q[DIGW-5:0], 4'h0};
		end
	end

	// Digits left to walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= CW'(NDIG);
		end else if (cmd.dig_shift || cmd.emit_dig) begin
			dcnt_q <= dcnt_q - CW'(1);
		end
	end

	// Prefix character
	always_comb begin
		case (op_q)
			i2a_pkg::OP_CHAR: pfx_byte = bin_q[7:0];
			i2a_pkg::OP_DEC:  pfx_byte = i2a_pkg::CH_MINUS;
			i2a_pkg::OP_PTR:  pfx_byte = zero_q ? i2a_pkg::nil_char(cmd.pidx)
				: (cmd.pidx[0] ? i2a_pkg::CH_X : i2a_pkg::CH_ZERO);
			default:          pfx_byte = i2a_pkg::CH_ZERO;
		endcase
	end

	// Output character register
	always_ff @(posedge clk) begin
		if (cmd.emit_pfx) begin
			out_q.ascii_byte <= pfx_byte;
			out_q.last       <= cmd.last;
		end else if (cmd.emit_dig) begin
			out_q.ascii_byte <= i2a_pkg::digit_char(top);
			out_q.last       <= cmd.last;
		end
	end

	assign text_data = out_q;

	assign status.op       = op_q;
	assign status.neg      = neg_q;
	assign status.zero     = zero_q;
	assign status.top_zero = (top == 4'h0);
	assign status.dcnt_one = (dcnt_q == CW'(1));

`ifndef ASSERT_OFF
	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_dig |-> dcnt_q != '0)
		else $error("digit emitted with no digits left");
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_dig && op_q == i2a_pkg::OP_DEC) |-> top < 4'd10)
		else $error("decimal digit out of range");
`endif

endmodule

// ===== design/i2a_ctrl.sv =====
// Controller: request handshake, sequencing of conversion, skip, prefix and digit output.
`timescale 1ns / 1ps

module i2a_ctrl #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              arg_valid,
	output logic              arg_stall,
	output logic              text_valid,
	input  logic              text_stall,
	input  i2a_pkg::status_t  status,
	output i2a_pkg::cmd_t     cmd
);

	localparam int ITW = $clog2(VALUE_WIDTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_CONV  = 6'b000100,
		S_SKIP  = 6'b001000,
		S_PFX   = 6'b010000,
		S_DIGS  = 6'b100000
	} state_t;

	state_t         state_q, state_d;
	logic [ITW-1:0] itc_q, itc_d;
	logic [2:0]     pidx_q, pidx_d;
	logic           out_valid_q, out_valid_d;
	logic           slot_free;
	logic [2:0]     plen;
	logic           pfx_only;

	assign slot_free  = !out_valid_q || !text_stall;
	assign arg_stall  = (state_q != S_IDLE);
	assign text_valid = out_valid_q;

	// Prefix length and whether the prefix is the whole run
	always_comb begin
		pfx_only = 1'b0;
		case (status.op)
			i2a_pkg::OP_CHAR: begin
				plen     = i2a_pkg::PFX_LEN_ONE;
				pfx_only = 1'b1;
			end
			i2a_pkg::OP_DEC:  plen = status.neg ? i2a_pkg::PFX_LEN_ONE : i2a_pkg::PFX_LEN_NONE;
			i2a_pkg::OP_PTR: begin
				plen     = status.zero ? i2a_pkg::PFX_LEN_NIL : i2a_pkg::PFX_LEN_HEX;
				pfx_only = status.zero;
			end
			default:          plen = i2a_pkg::PFX_LEN_NONE;
		endcase
	end

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		itc_d   = itc_q;
		pidx_d  = pidx_q;
		unique case (state_q)
			S_IDLE: begin
				if (arg_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				itc_d  = ITW'(VALUE_WIDTH - 1);
				pidx_d = '0;
				if (status.op == i2a_pkg::OP_DEC) begin
					state_d = S_CONV;
				end else if (pfx_only) begin
					state_d = S_PFX;
				end else begin
					state_d = S_SKIP;
				end
			end
			S_CONV: begin
				cmd.dab_step = 1'b1;
				if (itc_q == '0) begin
					state_d = S_SKIP;
				end else begin
					itc_d = itc_q - ITW'(1);
				end
			end
			S_SKIP: begin
				if (status.top_zero && !status.dcnt_one) begin
					cmd.dig_shift = 1'b1;
				end else if (plen != i2a_pkg::PFX_LEN_NONE) begin
					state_d = S_PFX;
				end else begin
					state_d = S_DIGS;
				end
			end
			S_PFX: begin
				if (slot_free) begin
					cmd.emit_pfx = 1'b1;
					cmd.pidx     = pidx_q;
					if (pidx_q == plen - 3'd1) begin
						if (pfx_only) begin
							cmd.last = 1'b1;
							state_d  = S_IDLE;
						end else begin
							state_d = S_DIGS;
						end
					end else begin
						pidx_d = pidx_q + 3'd1;
					end
				end
			end
			S_DIGS: begin
				if (slot_free) begin
					cmd.emit_dig = 1'b1;
					if (status.dcnt_one) begin
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output valid flag
	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.emit_pfx || cmd.emit_dig) begin
			out_valid_d = 1'b1;
		end else if (!text_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			itc_q       <= '0;
			pidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			itc_q       <= itc_d;
			pidx_q      <= pidx_d;
			out_valid_q <= out_valid_d;
		end
	end

`ifndef ASSERT_OFF
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pfx || cmd.emit_dig) |-> (!out_valid_q || !text_stall))
		else $error("character written over a held one");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_pfx || cmd.emit_dig) && cmd.last) |=> state_q == S_IDLE)
		else $error("run ended without returning to idle");
	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && itc_q != '0) |=> state_q == S_CONV)
		else $error("conversion left early");
`endif

endmodule

// ===== design/integer_to_ascii_formatter_core.sv =====
// Top level of the integer-to-ASCII formatter: controller and datapath.
//
//  channel | payload           | handshake             | direction
//  arg     | operation, value  | arg_valid / arg_stall | request in
//  text    | ascii_byte, last  | text_valid/text_stall | character out
//
// One request at a time; arg_stall is high from acceptance until the last character is written.
// Decimal: accept, start, shift-add-3 over every operand bit, skip of leading zero digits, then an
// optional minus sign and the digits. Hex skips leading zeros and emits the digits, pointer puts
// "0x" before them; a character emits only its byte and a null pointer only "(nil)".
// arst_n clears the controller; text_stall holds the output register and pauses output.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            arg_valid,
	output logic            arg_stall,
	input  i2a_pkg::arg_t   arg_data,
	output logic            text_valid,
	input  logic            text_stall,
	output i2a_pkg::text_t  text_data
);

	i2a_pkg::cmd_t    cmd;
	i2a_pkg::status_t status;

	i2a_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_stall (arg_stall),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.status    (status),
		.cmd       (cmd)
	);

	i2a_dpath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.arg_data (arg_data),
		.cmd      (cmd),
		.status   (status),
		.text_data(text_data)
	);

endmodule
